// ===== src/dwsc_pkg.sv =====
package dwsc_pkg;
	localparam int PixelCount = 65536;
	localparam int MaxSlices = 256;
	localparam logic [15:0] ThresholdReset = 16'd10240;
	localparam logic [8:0] MinDispReset = 9'd0;
	localparam logic [8:0] CountReset = 9'd64;
	localparam int CostW = 16;
	localparam int DispW = 18;
	localparam int NumW = 26;
	localparam int DenW = 19;
	localparam int ConfW = 17;

	localparam logic [1:0] RegThreshold = 2'd0;
	localparam logic [1:0] RegMinDisp = 2'd1;
	localparam logic [1:0] RegCount = 2'd2;

	typedef struct packed {
		logic [15:0] lo;
		logic [15:0] s2;
		logic [15:0] s3;
		logic [15:0] bef;
		logic [15:0] aft;
		logic [15:0] prv;
		logic [8:0] bs;
	} track_t;

	typedef struct packed {
		logic [15:0] pix;
		logic found;
		logic signed [DispW+1:0] base;
		logic refine;
		logic den_zero;
		logic neg;
		logic [NumW-1:0] an;
		logic [DenW-1:0] ad;
		logic conf_zero;
		logic [ConfW-1:0] cnum;
		logic [15:0] cdiv;
	} fin_t;
endpackage

// ===== src/dwsc_div.sv =====
// restoring divider, one quotient bit per stage
module dwsc_div #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int TW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	input logic [TW-1:0] tag_in,
	output logic out_valid,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	logic v_q [1:NW];
	logic [NW-1:0] n_q [1:NW];
	logic [DW-1:0] d_q [1:NW];
	logic [DW:0] r_q [1:NW];
	logic [TW-1:0] t_q [1:NW];

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic v_in;
		logic [NW-1:0] n_in;
		logic [DW-1:0] d_in;
		logic [DW:0] r_in;
		logic [TW-1:0] t_in;
		logic [DW+1:0] sh;
		logic [DW+1:0] df;
		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign n_in = num;
			assign d_in = den;
			assign r_in = '0;
			assign t_in = tag_in;
		end else begin : g_next
			assign v_in = v_q[i];
			assign n_in = n_q[i];
			assign d_in = d_q[i];
			assign r_in = r_q[i];
			assign t_in = t_q[i];
		end
		always_comb begin
			sh = {r_in, n_in[NW-1]};
			df = sh - {2'b0, d_in};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (adv) begin
				v_q[i+1] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				d_q[i+1] <= d_in;
				t_q[i+1] <= t_in;
				if (!df[DW+1]) begin
					r_q[i+1] <= df[DW:0];
					n_q[i+1] <= {n_in[NW-2:0], 1'b1};
				end else begin
					r_q[i+1] <= sh[DW:0];
					n_q[i+1] <= {n_in[NW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_q[NW];
	assign quo = n_q[NW];
	assign tag_out = t_q[NW];
endmodule

// ===== src/dwsc_track.sv =====
// per-pixel tracker: memory read, forward, update, write back
module dwsc_track #(
	parameter int PIXELS = dwsc_pkg::PixelCount,
	parameter int SLICES = dwsc_pkg::MaxSlices
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input logic [15:0] pix,
	input logic [7:0] sl,
	input logic [15:0] cost,
	input logic [15:0] thr,
	input logic [8:0] cnt,
	output logic out_valid,
	output logic [15:0] out_pix,
	output dwsc_pkg::track_t out_trk
);
	localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	// count register is 9 bits, so a larger limit never clips
	localparam logic [9:0] SlMax = (SLICES > 511) ? 10'd511 : 10'(SLICES);

	dwsc_pkg::track_t mem [PIXELS];

	logic [9:0] cnt_e;
	logic take;
	assign cnt_e = ({1'b0, cnt} > SlMax) ? SlMax : {1'b0, cnt};
	assign take = in_valid && (32'(pix) < 32'(PIXELS)) && ({2'b0, sl} < cnt_e);

	// stage 1: read
	logic v_s1, last_s1;
	logic [15:0] pix_s1, cost_s1, thr_s1;
	logic [7:0] sl_s1;
	dwsc_pkg::track_t rd_s1;
	// stage 2: updated record
	logic v_s2, last_s2;
	logic [15:0] pix_s2;
	dwsc_pkg::track_t up_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= pix;
			sl_s1 <= sl;
			cost_s1 <= cost;
			thr_s1 <= thr;
			last_s1 <= ({2'b0, sl} == cnt_e - 10'd1);
			rd_s1 <= mem[AW'(pix)];
		end
	end

	// forward the write in flight when the same pixel repeats
	dwsc_pkg::track_t cur, nx;
	always_comb begin
		cur = (v_s2 && pix_s2 == pix_s1) ? up_s2 : rd_s1;
		if (sl_s1 == 8'd0) begin
			cur = '{thr_s1, thr_s1, thr_s1, thr_s1, thr_s1, thr_s1, 9'd0};
		end
		nx = cur;
		if (cost_s1 < cur.lo) begin
			nx.s3 = cur.s2;
			nx.s2 = cur.lo;
			nx.lo = cost_s1;
			nx.bef = cur.prv;
			nx.aft = thr_s1;
			nx.bs = {1'b1, sl_s1};
		end else if (cost_s1 < cur.s2) begin
			nx.s3 = cur.s2;
			nx.s2 = cost_s1;
		end else if (cost_s1 < cur.s3) begin
			nx.s3 = cost_s1;
		end
		if (nx.bs[8] && {1'b0, sl_s1} == {1'b0, nx.bs[7:0]} + 9'd1) begin
			nx.aft = cost_s1;
		end
		nx.prv = cost_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s2 <= pix_s1;
			up_s2 <= nx;
			last_s2 <= last_s1;
			if (v_s1) begin
				mem[AW'(pix_s1)] <= nx;
			end
		end
	end

	assign out_valid = v_s2 && last_s2;
	assign out_pix = pix_s2;
	assign out_trk = up_s2;
endmodule

// ===== src/dwsc_final.sv =====
// final math: refine decision, two pipelined dividers, clamp
module dwsc_final (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input logic [15:0] pix,
	input dwsc_pkg::track_t trk,
	input logic [8:0] mind,
	output logic out_valid,
	output logic [15:0] out_pix,
	output logic [17:0] disparity,
	output logic [15:0] confidence,
	output logic match_found
);
	localparam int NW = dwsc_pkg::NumW;
	localparam int DW = dwsc_pkg::DenW;
	localparam int CW = dwsc_pkg::ConfW;
	localparam int BW = dwsc_pkg::DispW + 2;

	// stage a: operand prep
	dwsc_pkg::fin_t a_s1;
	logic v_s1;
	dwsc_pkg::fin_t f;
	logic [15:0] mn, cd;
	logic signed [18:0] den;
	logic signed [17:0] dnum;
	logic [16:0] adn;
	always_comb begin
		f.pix = pix;
		f.found = trk.bs[8];
		f.base = BW'(($signed(mind) + $signed({2'b0, trk.bs[7:0]})) * 256);
		mn = (trk.aft < trk.bef) ? trk.aft : trk.bef;
		f.refine = (mn <= trk.s2);
		den = 19'(2 * ($signed({3'b0, trk.aft}) + $signed({3'b0, trk.bef})
			- 2 * $signed({3'b0, trk.lo})));
		f.den_zero = (den == '0);
		dnum = $signed({2'b0, trk.aft}) - $signed({2'b0, trk.bef});
		adn = dnum[17] ? 17'(-dnum) : 17'(dnum);
		f.neg = dnum[17] != den[18];
		f.ad = den[18] ? DW'(-den) : DW'(den);
		// round half away: (2|n| + |d|) / (2|d|), here numerator carries 256
		f.an = NW'({adn, 9'b0}) + NW'(f.ad);
		f.ad = {f.ad[DW-2:0], 1'b0};
		cd = f.refine ? trk.s3 : trk.s2;
		f.conf_zero = (cd == 16'd0) || (cd <= trk.lo);
		f.cnum = CW'(cd - trk.lo);
		f.cdiv = cd;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) a_s1 <= f;
	end

	// offset quotient carries the item tag, confidence divider runs alongside
	logic v_q, v_c;
	logic [NW-1:0] q;
	dwsc_pkg::fin_t t_q;
	logic [CW+NW-1:0] cq;
	logic [CW+NW-1:0] cnum_w;
	logic [$bits(dwsc_pkg::fin_t)-1:0] tag_o;
	logic [0:0] cdum;
	assign cnum_w = {a_s1.cnum, {NW{1'b0}}} >> (NW - 16);

	dwsc_div #(.NW(NW), .DW(DW), .TW($bits(dwsc_pkg::fin_t))) u_off (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s1),
		.num(a_s1.an), .den(a_s1.ad), .tag_in(a_s1),
		.out_valid(v_q), .quo(q), .tag_out(tag_o));
	dwsc_div #(.NW(CW+NW), .DW(16), .TW(1)) u_conf (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s1),
		.num(cnum_w), .den(a_s1.cdiv), .tag_in(1'b0),
		.out_valid(v_c), .quo(cq), .tag_out(cdum));
	assign t_q = dwsc_pkg::fin_t'(tag_o);

	// confidence divider is CW stages longer: delay offset result to match
	logic [NW-1:0] qd [1:CW];
	dwsc_pkg::fin_t td [1:CW];
	for (genvar i = 0; i < CW; i++) begin : g_dl
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					qd[1] <= q;
					td[1] <= t_q;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					qd[i+1] <= qd[i];
					td[i+1] <= td[i];
				end
			end
		end
	end

	dwsc_pkg::fin_t e;
	logic signed [BW:0] dsp;
	logic signed [17:0] dsat;
	logic [15:0] csat;
	always_comb begin
		e = td[CW];
		dsp = (BW+1)'(e.base);
		if (e.refine && !e.den_zero) begin
			dsp = e.neg ? dsp + $signed({1'b0, (BW)'(qd[CW])})
				: dsp - $signed({1'b0, (BW)'(qd[CW])});
		end
		if (dsp < -(BW+1)'(65536)) dsat = -18'sd65536;
		else if (dsp > (BW+1)'(131071)) dsat = 18'sd131071;
		else dsat = dsp[17:0];
		csat = (cq > (CW+NW)'(65535)) ? 16'hFFFF : cq[15:0];
		if (e.conf_zero) csat = '0;
		if (!e.found) begin
			dsat = '0;
			csat = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_c;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_pix <= e.pix;
			disparity <= dsat;
			confidence <= csat;
			match_found <= e.found;
		end
	end
	logic unused;
	assign unused = ^{v_q, cdum};
endmodule

// ===== src/disparity_wta_subpixel_confidence_unit.sv =====
// pipeline from input transaction to result at m_tvalid: 2 tracker,
// 1 operand, 43 confidence divider and 1 output register stages
// throughput: one input transaction per cycle; the pipeline advances while the
// output register is empty or taken, tracker memory has one read and one write port
// reset: asynchronous active low arst_n clears valid bits and registers to
// reset values; tracker memory is undefined until slice 0 of a pixel is written
module disparity_wta_subpixel_confidence_unit #(
	parameter int PIXEL_COUNT = dwsc_pkg::PixelCount,
	parameter int MAX_SLICES = dwsc_pkg::MaxSlices
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [39:0] s_tdata, // pixel_index[15:0], slice[23:16], aggregated_cost[39:24]
	output logic m_tvalid,
	input logic m_tready,
	// out_pixel[15:0], disparity[33:16], confidence[49:34], zero [55:50]
	output logic [55:0] m_tdata,
	output logic [7:0] m_tuser, // match_found[0]
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [15:0] thr_q;
	logic [8:0] mind_q, cnt_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= dwsc_pkg::ThresholdReset;
			mind_q <= dwsc_pkg::MinDispReset;
			cnt_q <= dwsc_pkg::CountReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				dwsc_pkg::RegThreshold: thr_q <= pwdata[15:0];
				dwsc_pkg::RegMinDisp: mind_q <= pwdata[8:0];
				dwsc_pkg::RegCount: cnt_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			dwsc_pkg::RegThreshold: prdata = {16'd0, thr_q};
			dwsc_pkg::RegMinDisp: prdata = {23'd0, mind_q};
			dwsc_pkg::RegCount: prdata = {23'd0, cnt_q};
			default: prdata = '0;
		endcase
	end

	// whole pipeline stalls only when the output register is full and not taken
	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic tv;
	logic [15:0] tp;
	dwsc_pkg::track_t tt;
	dwsc_track #(.PIXELS(PIXEL_COUNT), .SLICES(MAX_SLICES)) u_track (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(s_tvalid),
		.pix(s_tdata[15:0]), .sl(s_tdata[23:16]), .cost(s_tdata[39:24]),
		.thr(thr_q), .cnt(cnt_q), .out_valid(tv), .out_pix(tp), .out_trk(tt));

	logic [15:0] opix;
	logic [17:0] dsp;
	logic [15:0] conf;
	logic fnd;
	dwsc_final u_final (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(tv), .pix(tp), .trk(tt),
		.mind(mind_q), .out_valid(m_tvalid), .out_pix(opix),
		.disparity(dsp), .confidence(conf), .match_found(fnd));
	assign m_tdata = {6'd0, conf, dsp, opix};
	assign m_tuser = {7'd0, fnd};

	// a stalled result must hold
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed under stall");
	// no match never reports a confidence
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[49:34] == 16'd0 && m_tdata[33:16] == 18'd0)
		else $error("no-match result not zero");
endmodule
